FILE: rtl/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants for the digest set store.
// ----------------------------------------------------------------------------
package dss_pkg;

  // Set size and the widths that follow from it
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // Digest layout: four 64-bit words, word0 in the low bits
  localparam int unsigned WORD_W = 64;
  localparam int unsigned KEY_W  = 4 * WORD_W;

  // Stream field widths
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned ECOUNT_W   = 7;
  localparam int unsigned OUT_DATA_W = 16;

  // Depth of the command queue between front and back (power of two)
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [MODE_W-1:0] {
    OP_INSERT   = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_CONTAINS = 2'd2,
    OP_CLEAR    = 2'd3
  } op_e;

  typedef logic [KEY_W-1:0] key_t;

  // One classified command as it sits in the queue
  typedef struct packed {
    op_e  op;
    key_t key;
  } cmd_t;

  // One result beat
  typedef struct packed {
    logic [ECOUNT_W-1:0] entry_count;
    logic                status;
    logic                was_present;
  } res_t;

endpackage

FILE: rtl/digest_set_store_unit.sv
// ----------------------------------------------------------------------------
// digest_set_store_unit
// Set of 256-bit digests with insert, remove, contains and clear.
// ----------------------------------------------------------------------------
// Each request beat carries a mode in tuser and a 256-bit digest in tdata and
// returns one result beat. The set holds up to CAPACITY digests in a single
// memory searched one entry per cycle. The search engine scans the filled
// entries in order and stops at the first hit; a remove that moves the last
// entry into the freed slot adds a read and a write of that entry, and clear
// skips the scan. A result waiting on the sink holds the engine in its
// response state. Requests pass through the input register and the queue
// before they reach the engine. A two-deep command queue lets requests be
// taken while a search runs, and the result register holds a finished beat
// while the next command starts. An insert into a full set reports status 1
// and leaves the set unchanged.
// ----------------------------------------------------------------------------
module digest_set_store_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [63:0] key_word0, [127:64] key_word1, [191:128] key_word2,
  // [255:192] key_word3
  input  logic [255:0] s_axis_tdata_i,
  // [1:0] mode
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] was_present, [1] status, [8:2] entry_count, [15:9] zero
  output logic [15:0] m_axis_tdata_o
);

  logic          push_vld, push_rdy;
  dss_pkg::cmd_t push_cmd;
  logic          pop_vld, pop;
  dss_pkg::cmd_t pop_cmd;
  dss_pkg::res_t res;

  dss_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_key_i    (s_axis_tdata_i),
    .s_mode_i   (s_axis_tuser_i),
    .push_vld_o (push_vld),
    .push_rdy_i (push_rdy),
    .push_cmd_o (push_cmd)
  );

  dss_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_vld_i (push_vld),
    .push_rdy_o (push_rdy),
    .push_cmd_i (push_cmd),
    .pop_vld_o  (pop_vld),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd)
  );

  dss_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_vld_i  (pop_vld),
    .cmd_i      (pop_cmd),
    .cmd_pop_o  (pop),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .res_o      (res)
  );

  // Result beat packing, zero padded to whole bytes
  assign m_axis_tdata_o = {7'd0, res.entry_count, res.status, res.was_present};

endmodule

FILE: rtl/dss_front.sv
// ----------------------------------------------------------------------------
// dss_front
// Input stage: takes request beats, decodes the mode and holds the command
// until the queue takes it.
// ----------------------------------------------------------------------------
module dss_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_tvalid_i,
  output logic                       s_tready_o,
  input  logic [dss_pkg::KEY_W-1:0]  s_key_i,
  input  logic [dss_pkg::MODE_W-1:0] s_mode_i,
  output logic                       push_vld_o,
  input  logic                       push_rdy_i,
  output dss_pkg::cmd_t              push_cmd_o
);

  logic          hold_vld_q, hold_vld_d;
  dss_pkg::cmd_t hold_q;
  dss_pkg::op_e  op_dec;
  logic          accept;

  // Mode decode: every mode value names an operation
  always_comb begin
    op_dec = dss_pkg::op_e'(s_mode_i);
  end

  assign s_tready_o = !hold_vld_q || push_rdy_i;
  assign accept     = s_tvalid_i && s_tready_o;

  always_comb begin
    hold_vld_d = hold_vld_q;
    if (accept) begin
      hold_vld_d = 1'b1;
    end else if (push_rdy_i) begin
      hold_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
    end else begin
      hold_vld_q <= hold_vld_d;
    end
  end

  // Command holding register, payload only
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_q.op  <= op_dec;
      hold_q.key <= s_key_i;
    end
  end

  assign push_vld_o = hold_vld_q;
  assign push_cmd_o = hold_q;

endmodule

FILE: rtl/dss_queue.sv
// ----------------------------------------------------------------------------
// dss_queue
// Short command FIFO that lets the front and the search engine stall apart.
// ----------------------------------------------------------------------------
module dss_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_vld_i,
  output logic          push_rdy_o,
  input  dss_pkg::cmd_t push_cmd_i,
  output logic          pop_vld_o,
  input  logic          pop_i,
  output dss_pkg::cmd_t pop_cmd_o
);

  dss_pkg::cmd_t                entries_q [dss_pkg::QDEPTH];
  logic [dss_pkg::QAW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [dss_pkg::QAW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [dss_pkg::QCW-1:0]      count_q, count_d;
  logic                         do_push, do_pop;

  assign push_rdy_o = (count_q != dss_pkg::QCW'(dss_pkg::QDEPTH));
  assign pop_vld_o  = (count_q != '0);
  assign do_push    = push_vld_i && push_rdy_o;
  assign do_pop     = pop_i && pop_vld_o;
  assign pop_cmd_o  = entries_q[rd_ptr_q];

  // Pointer and occupancy update; depth is a power of two so pointers wrap
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

FILE: rtl/dss_back.sv
// ----------------------------------------------------------------------------
// dss_back
// Search engine: holds the digest memory, scans it one entry per cycle,
// applies insert, remove, contains or clear and registers the result beat.
// ----------------------------------------------------------------------------
module dss_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_vld_i,
  input  dss_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          m_tvalid_o,
  input  logic          m_tready_i,
  output dss_pkg::res_t res_o
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_SCAN    = 6'b000010,
    ST_UPDATE  = 6'b000100,
    ST_MOVE_RD = 6'b001000,
    ST_MOVE_WR = 6'b010000,
    ST_RESP    = 6'b100000
  } state_e;

  state_e                       state_q, state_d;
  dss_pkg::cmd_t                cmd_q, cmd_d;
  logic [dss_pkg::CNT_W-1:0]    fill_q, fill_d;
  logic [dss_pkg::CNT_W-1:0]    issue_idx_q, issue_idx_d;
  logic                         cmp_vld_q, cmp_vld_d;
  logic [dss_pkg::ADDR_W-1:0]   cmp_idx_q, cmp_idx_d;
  logic [dss_pkg::ADDR_W-1:0]   slot_q, slot_d;
  logic                         present_q, present_d;
  logic                         status_q, status_d;
  logic                         out_vld_q, out_vld_d;
  dss_pkg::res_t                out_q;
  logic                         out_load;

  // Digest memory: one write and one registered read per cycle
  dss_pkg::key_t                mem_q [dss_pkg::CAPACITY];
  dss_pkg::key_t                rd_data_q;
  logic                         rd_en, wr_en;
  logic [dss_pkg::ADDR_W-1:0]   rd_addr, wr_addr;
  dss_pkg::key_t                wr_data;

  logic [dss_pkg::ADDR_W-1:0]   last_idx;
  logic                         hit;

  assign last_idx = dss_pkg::ADDR_W'(fill_q - 1'b1);
  assign hit      = cmp_vld_q && (rd_data_q == cmd_q.key);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    fill_d      = fill_q;
    issue_idx_d = issue_idx_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    slot_d      = slot_q;
    present_d   = present_q;
    status_d    = status_q;
    cmd_pop_o   = 1'b0;
    out_load    = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = cmd_q.key;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_vld_i) begin
          cmd_pop_o   = 1'b1;
          cmd_d       = cmd_i;
          present_d   = 1'b0;
          status_d    = 1'b0;
          issue_idx_d = '0;
          if (cmd_i.op == dss_pkg::OP_CLEAR) begin
            fill_d  = '0;
            state_d = ST_RESP;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      // Read one entry per cycle, compare the previous one
      ST_SCAN: begin
        if (hit) begin
          present_d = 1'b1;
          slot_d    = cmp_idx_q;
          state_d   = ST_UPDATE;
        end else if (issue_idx_q < fill_q) begin
          rd_en       = 1'b1;
          rd_addr     = issue_idx_q[dss_pkg::ADDR_W-1:0];
          issue_idx_d = issue_idx_q + 1'b1;
          cmp_vld_d   = 1'b1;
          cmp_idx_d   = issue_idx_q[dss_pkg::ADDR_W-1:0];
        end else if (!cmp_vld_q) begin
          present_d = 1'b0;
          state_d   = ST_UPDATE;
        end
      end

      ST_UPDATE: begin
        state_d = ST_RESP;
        unique case (cmd_q.op)
          dss_pkg::OP_INSERT: begin
            if (!present_q) begin
              if (fill_q == dss_pkg::CNT_W'(dss_pkg::CAPACITY)) begin
                status_d = 1'b1;
              end else begin
                wr_en   = 1'b1;
                wr_addr = fill_q[dss_pkg::ADDR_W-1:0];
                fill_d  = fill_q + 1'b1;
              end
            end
          end
          dss_pkg::OP_REMOVE: begin
            if (present_q) begin
              if (slot_q == last_idx) begin
                fill_d = fill_q - 1'b1;
              end else begin
                state_d = ST_MOVE_RD;
              end
            end
          end
          default: begin
          end
        endcase
      end

      // Fetch the last entry to fill the hole
      ST_MOVE_RD: begin
        rd_en   = 1'b1;
        rd_addr = last_idx;
        state_d = ST_MOVE_WR;
      end

      ST_MOVE_WR: begin
        wr_en   = 1'b1;
        wr_addr = slot_q;
        wr_data = rd_data_q;
        fill_d  = fill_q - 1'b1;
        state_d = ST_RESP;
      end

      ST_RESP: begin
        if (!out_vld_q || m_tready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register valid
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (m_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      issue_idx_q <= '0;
      cmp_vld_q   <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      issue_idx_q <= issue_idx_d;
      cmp_vld_q   <= cmp_vld_d;
      out_vld_q   <= out_vld_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    cmp_idx_q <= cmp_idx_d;
    slot_q    <= slot_d;
    present_q <= present_d;
    status_q  <= status_d;
    if (out_load) begin
      out_q.was_present <= present_q;
      out_q.status      <= status_q;
      out_q.entry_count <= dss_pkg::ECOUNT_W'(fill_q);
    end
  end

  // Memory ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign res_o      = out_q;

endmodule

FILE: dv/tb_digest_set_store_unit.sv
// ----------------------------------------------------------------------------
// tb_digest_set_store_unit
// Self-checking bench for the digest set store.
// ----------------------------------------------------------------------------
// Request beats (mode plus 256-bit digest) are driven on the slave stream.
// A mirror of the set works out the result of every accepted beat: presence,
// full-set refusal and entry count. Result beats are compared against those
// results in order. A short directed run covers the corner cases, then random
// phases use key pools of varying size so that hits, near misses, filling to
// capacity and draining all occur. Both sides idle at random, and the sink
// holds off for a long stretch once to back the block up.
// ----------------------------------------------------------------------------
module tb_digest_set_store_unit;

  localparam int unsigned CYCLE_LIMIT     = 1000000;
  localparam int unsigned SETTLE_CYCLES   = dss_pkg::CAPACITY + 16;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned POOL_SIZE       = 128;

  // Directed keys: all zero, all one, and keys one bit away from zero
  localparam dss_pkg::key_t KEY_ZERO = '0;
  localparam dss_pkg::key_t KEY_ONES = '1;
  localparam dss_pkg::key_t KEY_TOP  = dss_pkg::key_t'(1) << (dss_pkg::KEY_W - 1);
  localparam dss_pkg::key_t KEY_LOW  = dss_pkg::key_t'(1);

  // Mirror of the stored set and queue of results still to arrive
  class digest_set_mirror;
    dss_pkg::key_t slots [dss_pkg::CAPACITY];
    int unsigned   fill;
    dss_pkg::res_t awaited [$];
    int unsigned   mismatches;
    int unsigned   beats_seen;
    int unsigned   op_count [4];
    int unsigned   hits;
    int unsigned   full_rejects;
    int unsigned   peak_fill;

    function void note_request(dss_pkg::op_e op, dss_pkg::key_t key);
      dss_pkg::res_t outcome;
      int            slot;
      int unsigned   idx;
      outcome = '0;
      slot    = -1;
      op_count[op]++;
      if (op == dss_pkg::OP_CLEAR) begin
        fill = 0;
      end else begin
        // linear search over the valid entries only
        for (idx = 0; idx < fill; idx++)
          if (slot < 0 && slots[idx] == key) slot = idx;
        outcome.was_present = (slot >= 0);
        if (slot >= 0) hits++;
        if (op == dss_pkg::OP_INSERT && slot < 0) begin
          if (fill >= dss_pkg::CAPACITY) begin
            outcome.status = 1'b1;
            full_rejects++;
          end else begin
            slots[fill] = key;
            fill++;
          end
        end else if (op == dss_pkg::OP_REMOVE && slot >= 0) begin
          // last entry moves into the freed slot
          slots[slot] = slots[fill-1];
          fill--;
        end
      end
      if (fill > peak_fill) peak_fill = fill;
      outcome.entry_count = dss_pkg::ECOUNT_W'(fill);
      awaited.push_back(outcome);
    endfunction

    function void flag(string field, logic [15:0] want, logic [15:0] seen);
      mismatches++;
      if (mismatches <= 10)
        $display("result beat %0d: %s expected %0d, got %0d", beats_seen, field, want, seen);
    endfunction

    function void check_result(logic [dss_pkg::OUT_DATA_W-1:0] beat);
      dss_pkg::res_t want;
      dss_pkg::res_t seen;
      seen = beat[$bits(dss_pkg::res_t)-1:0];
      beats_seen++;
      if (awaited.size() == 0) begin
        flag("unexpected beat", '0, beat);
        return;
      end
      want = awaited.pop_front();
      if (seen.was_present !== want.was_present)
        flag("was_present", 16'(want.was_present), 16'(seen.was_present));
      if (seen.status !== want.status)
        flag("status", 16'(want.status), 16'(seen.status));
      if (seen.entry_count !== want.entry_count)
        flag("entry_count", 16'(want.entry_count), 16'(seen.entry_count));
      if (beat[dss_pkg::OUT_DATA_W-1:$bits(dss_pkg::res_t)] !== '0)
        flag("padding", '0, 16'(beat[dss_pkg::OUT_DATA_W-1:$bits(dss_pkg::res_t)]));
    endfunction
  endclass

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           req_valid = 1'b0;
  logic                           req_ready;
  logic [dss_pkg::KEY_W-1:0]      req_key   = '0;
  logic [dss_pkg::MODE_W-1:0]     req_mode  = dss_pkg::OP_INSERT;
  logic                           res_valid;
  logic                           res_ready = 1'b0;
  logic [dss_pkg::OUT_DATA_W-1:0] res_beat;

  digest_set_mirror mirror = new;
  dss_pkg::key_t    key_pool [POOL_SIZE];
  bit               tx_idle   = 1'b1;
  bit               rx_stalls = 1'b1;
  int unsigned      rx_hold   = 0;
  int unsigned      cycle_count;

  digest_set_store_unit u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (req_valid),
    .s_axis_tready_o (req_ready),
    .s_axis_tdata_i  (req_key),
    .s_axis_tuser_i  (req_mode),
    .m_axis_tvalid_o (res_valid),
    .m_axis_tready_i (res_ready),
    .m_axis_tdata_o  (res_beat)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             mirror.awaited.size());
    $display("** digest_set_store_unit: FAILED **");
    $finish;
  end

  function automatic dss_pkg::key_t random_key();
    dss_pkg::key_t k;
    int            i;
    for (i = 0; i < dss_pkg::KEY_W / 32; i++) k[i*32 +: 32] = $urandom();
    return k;
  endfunction

  // Offer one request beat and wait until it is taken
  task automatic send_request(dss_pkg::op_e op, dss_pkg::key_t key);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 5) : 0;
    @(negedge clk);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req_mode  <= op;
    req_key   <= key;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    mirror.note_request(op, key);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_drained();
    @(negedge clk);
    req_valid <= 1'b0;
    while (mirror.awaited.size() != 0) @(posedge clk);
  endtask

  // Random requests drawn from the first pool_n pool keys, with some near
  // misses (one bit flipped) and some fresh keys mixed in
  task automatic run_phase(int unsigned items, int unsigned pool_n, int unsigned pct_clear,
                           int unsigned pct_insert, int unsigned pct_remove);
    int unsigned   n;
    int unsigned   pick;
    dss_pkg::op_e  op;
    dss_pkg::key_t key;
    for (n = 0; n < items; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < pct_clear)
        op = dss_pkg::OP_CLEAR;
      else if (pick < pct_clear + pct_insert)
        op = dss_pkg::OP_INSERT;
      else if (pick < pct_clear + pct_insert + pct_remove)
        op = dss_pkg::OP_REMOVE;
      else
        op = dss_pkg::OP_CONTAINS;
      key  = key_pool[$urandom_range(0, pool_n - 1)];
      pick = $urandom_range(0, 99);
      if (pick >= 90)
        key = random_key();
      else if (pick >= 80)
        key = key ^ (dss_pkg::key_t'(1) << $urandom_range(0, dss_pkg::KEY_W - 1));
      send_request(op, key);
    end
  endtask

  // Result sink: random stalls per beat, one long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    wait (rst_n);
    forever begin
      stall   = (rx_hold != 0) ? rx_hold : (rx_stalls ? $urandom_range(0, 5) : 0);
      rx_hold = 0;
      @(negedge clk);
      if (stall != 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ready <= 1'b1;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
      mirror.check_result(res_beat);
    end
  end

  // Main sequence
  initial begin : stimulus
    int unsigned i;
    key_pool[0] = KEY_ZERO;
    key_pool[1] = KEY_ONES;
    for (i = 2; i < POOL_SIZE; i++) key_pool[i] = random_key();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed corner cases
    send_request(dss_pkg::OP_CONTAINS, KEY_ZERO);  // empty set
    send_request(dss_pkg::OP_REMOVE,   KEY_ZERO);  // remove from empty set
    send_request(dss_pkg::OP_INSERT,   KEY_ZERO);
    send_request(dss_pkg::OP_INSERT,   KEY_ONES);
    send_request(dss_pkg::OP_INSERT,   KEY_ZERO);  // already present
    send_request(dss_pkg::OP_INSERT,   KEY_TOP);   // differs in top bit only
    send_request(dss_pkg::OP_CONTAINS, KEY_ZERO);
    send_request(dss_pkg::OP_CONTAINS, KEY_LOW);   // differs in bottom bit only
    send_request(dss_pkg::OP_REMOVE,   KEY_ONES);  // middle entry, last one moves up
    send_request(dss_pkg::OP_CONTAINS, KEY_TOP);   // found in its new slot
    send_request(dss_pkg::OP_CONTAINS, KEY_ONES);
    send_request(dss_pkg::OP_REMOVE,   KEY_TOP);   // last entry
    send_request(dss_pkg::OP_REMOVE,   KEY_TOP);   // now absent
    send_request(dss_pkg::OP_INSERT,   KEY_LOW);
    send_request(dss_pkg::OP_CLEAR,    KEY_ONES);
    send_request(dss_pkg::OP_CONTAINS, KEY_ZERO);  // gone after clear
    send_request(dss_pkg::OP_INSERT,   KEY_ONES);
    send_request(dss_pkg::OP_REMOVE,   KEY_ONES);  // only entry
    send_request(dss_pkg::OP_CLEAR,    KEY_ZERO);  // clear on empty set
    wait_drained();

    // small pool: heavy churn of duplicates
    run_phase(200, 6, 3, 35, 30);
    wait_drained();
    // insert-heavy: set fills and refuses; sink holds off meanwhile
    rx_hold = HOLD_OFF_CYCLES;
    run_phase(200, 100, 0, 75, 5);
    // remove-heavy: set drains from full
    run_phase(200, 100, 0, 30, 45);
    wait_drained();
    // back to back on both sides
    tx_idle   = 1'b0;
    rx_stalls = 1'b0;
    run_phase(200, 20, 5, 40, 30);
    tx_idle   = 1'b1;
    run_phase(300, 70, 1, 40, 25);
    wait_drained();
    tx_idle   = 1'b0;
    rx_stalls = 1'b1;
    run_phase(300, POOL_SIZE, 2, 60, 20);
    tx_idle   = 1'b1;
    run_phase(200, 90, 1, 50, 25);
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d requests (insert %0d, remove %0d, contains %0d, clear %0d), %0d hits",
             mirror.op_count[dss_pkg::OP_INSERT] + mirror.op_count[dss_pkg::OP_REMOVE] +
             mirror.op_count[dss_pkg::OP_CONTAINS] + mirror.op_count[dss_pkg::OP_CLEAR],
             mirror.op_count[dss_pkg::OP_INSERT], mirror.op_count[dss_pkg::OP_REMOVE],
             mirror.op_count[dss_pkg::OP_CONTAINS], mirror.op_count[dss_pkg::OP_CLEAR],
             mirror.hits);
    $display("%0d inserts refused on a full set, peak fill %0d of %0d, %0d beats, %0d mismatches",
             mirror.full_rejects, mirror.peak_fill, dss_pkg::CAPACITY, mirror.beats_seen,
             mirror.mismatches);
    if (mirror.mismatches == 0 && mirror.awaited.size() == 0) begin
      $display("** digest_set_store_unit: PASSED **");
    end else begin
      $display("** digest_set_store_unit: FAILED **");
    end
    $finish;
  end

endmodule
